FILE: sv/rmes_pkg.sv
// Shared types and constants for the register machine execute step.
`default_nettype none
package rmes_pkg;

  localparam int MEM_WORDS = 65536;
  localparam int MEM_AW    = $clog2(MEM_WORDS);
  localparam int REG_COUNT = 16;
  localparam int REG_AW    = $clog2(REG_COUNT);

  localparam logic [REG_AW-1:0] SP_REG = REG_AW'(14);

  localparam logic [1:0] FN_LOAD  = 2'd0;
  localparam logic [1:0] FN_START = 2'd1;
  localparam logic [1:0] FN_STEP  = 2'd2;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_CALL  = 3'd1;
  localparam logic [2:0] ST_EXIT  = 3'd2;
  localparam logic [2:0] ST_BADOP = 3'd3;
  localparam logic [2:0] ST_DIVZ  = 3'd4;

  localparam logic [1:0] FLAG_EQ = 2'd0;
  localparam logic [1:0] FLAG_GT = 2'd1;
  localparam logic [1:0] FLAG_LT = 2'd3;

  localparam logic [7:0] OP_SYSCALL = 8'd1;
  localparam logic [7:0] OP_ADD     = 8'd2;
  localparam logic [7:0] OP_ADDI    = 8'd3;
  localparam logic [7:0] OP_SUB     = 8'd4;
  localparam logic [7:0] OP_SUBI    = 8'd5;
  localparam logic [7:0] OP_MUL     = 8'd6;
  localparam logic [7:0] OP_MULI    = 8'd7;
  localparam logic [7:0] OP_DIV     = 8'd8;
  localparam logic [7:0] OP_DIVI    = 8'd9;
  localparam logic [7:0] OP_LC      = 8'd12;
  localparam logic [7:0] OP_SHL     = 8'd13;
  localparam logic [7:0] OP_SHLI    = 8'd14;
  localparam logic [7:0] OP_SHR     = 8'd15;
  localparam logic [7:0] OP_SHRI    = 8'd16;
  localparam logic [7:0] OP_AND     = 8'd17;
  localparam logic [7:0] OP_ANDI    = 8'd18;
  localparam logic [7:0] OP_OR      = 8'd19;
  localparam logic [7:0] OP_ORI     = 8'd20;
  localparam logic [7:0] OP_XOR     = 8'd21;
  localparam logic [7:0] OP_XORI    = 8'd22;
  localparam logic [7:0] OP_NOT     = 8'd23;
  localparam logic [7:0] OP_MOV     = 8'd24;
  localparam logic [7:0] OP_PUSH    = 8'd38;
  localparam logic [7:0] OP_POP     = 8'd39;
  localparam logic [7:0] OP_CALLR   = 8'd40;
  localparam logic [7:0] OP_CALL    = 8'd41;
  localparam logic [7:0] OP_RET     = 8'd42;
  localparam logic [7:0] OP_CMP     = 8'd43;
  localparam logic [7:0] OP_CMPI    = 8'd44;
  localparam logic [7:0] OP_JMP     = 8'd46;
  localparam logic [7:0] OP_JNE     = 8'd47;
  localparam logic [7:0] OP_JEQ     = 8'd48;
  localparam logic [7:0] OP_JLE     = 8'd49;
  localparam logic [7:0] OP_JL      = 8'd50;
  localparam logic [7:0] OP_JGE     = 8'd51;
  localparam logic [7:0] OP_JG      = 8'd52;
  localparam logic [7:0] OP_LOAD    = 8'd68;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] address;
    logic [31:0] data;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] next_pc;
    logic [19:0] call_code;
    logic [3:0]  call_reg;
    logic [31:0] call_value;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DEC, S_RA, S_RB, S_SP, S_EXEC, S_MEMW,
    S_MUL, S_DIV, S_DIVW, S_WR2, S_OUT
  } state_t;

endpackage
`default_nettype wire

FILE: sv/rmes_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module rmes_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: sv/register_machine_execute_step.sv
// Top level of the register machine execute step.
// Usage:
//   Input channel in_valid/in_stall carries one request: a memory load, a start
//   or one instruction step. Each request gives exactly one result on
//   out_valid/out_stall (status, next pc, syscall fields).
//   cfg_we/cfg_data write the exit syscall code; the user writes it only while
//   the block is idle, which the block itself does not enforce.
// Sequence, set by the sequencer walking one request through the main memory
//   and the register file (one read port, one write port each): load, start,
//   unused func go straight to the result state. step: fetch, three register
//   reads, execute, then a memory read or a second register write (pop: both);
//   multiply, divide (one quotient bit per cycle) add states. One request at a time.
// Reset clears pc, compare flag, exit code and all register valid bits
//   (registers read as zero). Main memory is not cleared.
// A stalled result waits in the output register; the next request is taken
//   meanwhile, and its result waits until the output register frees.
`default_nettype none
module register_machine_execute_step
  import rmes_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data,
  input  wire logic      cfg_we,
  input  wire logic [19:0] cfg_data
);

  state_t state_r, state_nxt;
  logic [15:0] pc_r, pc_nxt;
  logic [1:0]  flag_r, flag_nxt;
  logic [19:0] exit_r;
  logic [REG_COUNT-1:0] rf_vld_r, rf_vld_nxt;
  logic        rvld_r, rvld_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_r, out_nxt;

  logic [31:0] ir_r, ir_nxt;
  logic [31:0] a_r, a_nxt, b_r, b_nxt, sp_r, sp_nxt;
  logic [2:0]  st_r, st_nxt;
  logic [19:0] code_r, code_nxt;
  logic [3:0]  creg_r, creg_nxt;
  logic [31:0] cval_r, cval_nxt;
  logic [63:0] prod_r, prod_nxt;
  logic        mneg_r, mneg_nxt;
  logic [31:0] rem_r, rem_nxt, quo_r, quo_nxt, dvs_r, dvs_nxt;
  logic        dneg_r, dneg_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [REG_AW-1:0] wr2_addr_r, wr2_addr_nxt;
  logic [31:0] wr2_data_r, wr2_data_nxt;

  logic              mem_we;
  logic [MEM_AW-1:0] mem_waddr, mem_raddr;
  logic [31:0]       mem_wdata, mem_rdata;
  logic              rf_we;
  logic [REG_AW-1:0] rf_waddr, rf_raddr;
  logic [31:0]       rf_wdata, rf_rdata, rf_rd;

  logic [7:0]  op;
  logic [REG_AW-1:0] ra, rb;
  logic [31:0] ri, rr, rm32, b_rr, sp_m1, shv, md, popv;
  logic [32:0] dsh, ddif;
  logic [63:0] q64;
  logic        take;

  rmes_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_mem (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(mem_rdata)
  );

  rmes_ram #(.WIDTH(32), .DEPTH(REG_COUNT)) u_rf (
    .clk(clk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
    .raddr(rf_raddr), .rdata(rf_rdata)
  );

  assign rf_rd     = rvld_r ? rf_rdata : 32'd0;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign op    = ir_r[31:24];
  assign ra    = ir_r[23:20];
  assign rb    = ir_r[19:16];
  assign ri    = {{12{ir_r[19]}}, ir_r[19:0]};
  assign rr    = {{16{ir_r[15]}}, ir_r[15:0]};
  assign rm32  = {12'd0, ir_r[19:0]};
  assign b_rr  = b_r + rr;
  assign sp_m1 = sp_r - 32'd1;
  assign md    = mem_rdata;
  assign popv  = md + ri;
  assign dsh   = {rem_r, quo_r[31]};
  assign ddif  = dsh - {1'b0, dvs_r};
  assign q64   = {32'd0, quo_r};

  always_comb begin
    state_nxt     = state_r;
    pc_nxt        = pc_r;
    flag_nxt      = flag_r;
    rf_vld_nxt    = rf_vld_r;
    rvld_nxt      = rvld_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    ir_nxt        = ir_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    sp_nxt        = sp_r;
    st_nxt        = st_r;
    code_nxt      = code_r;
    creg_nxt      = creg_r;
    cval_nxt      = cval_r;
    prod_nxt      = prod_r;
    mneg_nxt      = mneg_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    dvs_nxt       = dvs_r;
    dneg_nxt      = dneg_r;
    cnt_nxt       = cnt_r;
    wr2_addr_nxt  = wr2_addr_r;
    wr2_data_nxt  = wr2_data_r;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = 32'd0;
    mem_raddr     = '0;
    rf_we         = 1'b0;
    rf_waddr      = '0;
    rf_wdata      = 32'd0;
    rf_raddr      = '0;
    shv           = 32'd0;
    take          = 1'b0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          st_nxt    = ST_OK;
          code_nxt  = 20'd0;
          creg_nxt  = 4'd0;
          cval_nxt  = 32'd0;
          state_nxt = S_OUT;
          case (in_data.func)
            FN_LOAD: begin
              mem_we    = 1'b1;
              mem_waddr = MEM_AW'(in_data.address);
              mem_wdata = in_data.data;
            end
            FN_START: begin
              pc_nxt     = in_data.address;
              rf_vld_nxt = '0;
              rf_we      = 1'b1;
              rf_waddr   = SP_REG;
              rf_wdata   = 32'(MEM_WORDS);
            end
            FN_STEP: begin
              mem_raddr = MEM_AW'(pc_r);
              pc_nxt    = pc_r + 16'd1;
              state_nxt = S_DEC;
            end
            default: begin
            end
          endcase
        end
      end
      S_DEC: begin
        ir_nxt    = mem_rdata;
        rf_raddr  = mem_rdata[23:20];
        rvld_nxt  = rf_vld_r[mem_rdata[23:20]];
        state_nxt = S_RA;
      end
      S_RA: begin
        a_nxt     = rf_rd;
        rf_raddr  = rb;
        rvld_nxt  = rf_vld_r[rb];
        state_nxt = S_RB;
      end
      S_RB: begin
        b_nxt     = rf_rd;
        rf_raddr  = SP_REG;
        rvld_nxt  = rf_vld_r[SP_REG];
        state_nxt = S_SP;
      end
      S_SP: begin
        sp_nxt    = rf_rd;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_OUT;
        rf_waddr  = ra;
        case (op)
          OP_SYSCALL: begin
            code_nxt = ir_r[19:0];
            creg_nxt = ra;
            cval_nxt = a_r;
            st_nxt   = (ir_r[19:0] == exit_r) ? ST_EXIT : ST_CALL;
          end
          OP_ADD:  begin rf_we = 1'b1; rf_wdata = a_r + b_rr; end
          OP_ADDI: begin rf_we = 1'b1; rf_wdata = a_r + ri; end
          OP_SUB:  begin rf_we = 1'b1; rf_wdata = a_r - b_rr; end
          OP_SUBI: begin rf_we = 1'b1; rf_wdata = a_r - ri; end
          OP_MUL: begin
            prod_nxt  = {32'd0, a_r} * {32'd0, b_rr};
            mneg_nxt  = 1'b0;
            state_nxt = S_MUL;
          end
          OP_MULI: begin
            prod_nxt  = {32'd0, a_r} * {32'd0, ri};
            mneg_nxt  = ri[31];
            state_nxt = S_MUL;
          end
          OP_DIV: begin
            if (b_rr == 32'd0) begin
              st_nxt = ST_DIVZ;
            end else begin
              dvs_nxt   = b_rr;
              dneg_nxt  = 1'b0;
              rem_nxt   = 32'd0;
              quo_nxt   = a_r;
              cnt_nxt   = 5'd0;
              state_nxt = S_DIV;
            end
          end
          OP_DIVI: begin
            if (ri == 32'd0) begin
              st_nxt = ST_DIVZ;
            end else begin
              dvs_nxt   = ri[31] ? (32'd0 - ri) : ri;
              dneg_nxt  = ri[31];
              rem_nxt   = 32'd0;
              quo_nxt   = a_r;
              cnt_nxt   = 5'd0;
              state_nxt = S_DIV;
            end
          end
          OP_LC: begin rf_we = 1'b1; rf_wdata = ri; end
          OP_SHL, OP_SHLI: begin
            shv      = (op == OP_SHL) ? b_r : ri;
            rf_we    = 1'b1;
            rf_wdata = (|shv[31:5]) ? 32'd0 : (a_r << shv[4:0]);
          end
          OP_SHR, OP_SHRI: begin
            shv      = (op == OP_SHR) ? b_r : ri;
            rf_we    = 1'b1;
            rf_wdata = (|shv[31:5]) ? 32'd0 : (a_r >> shv[4:0]);
          end
          OP_AND:  begin rf_we = 1'b1; rf_wdata = a_r & b_r; end
          OP_ANDI: begin rf_we = 1'b1; rf_wdata = a_r & ri; end
          OP_OR:   begin rf_we = 1'b1; rf_wdata = a_r | b_r; end
          OP_ORI:  begin rf_we = 1'b1; rf_wdata = a_r | ri; end
          OP_XOR:  begin rf_we = 1'b1; rf_wdata = a_r ^ b_r; end
          OP_XORI: begin rf_we = 1'b1; rf_wdata = a_r ^ ri; end
          OP_NOT:  begin rf_we = 1'b1; rf_wdata = ~a_r; end
          OP_MOV:  begin rf_we = 1'b1; rf_wdata = b_rr; end
          OP_PUSH: begin
            rf_we     = 1'b1;
            rf_waddr  = SP_REG;
            rf_wdata  = sp_m1;
            mem_we    = 1'b1;
            mem_waddr = sp_m1[MEM_AW-1:0];
            mem_wdata = ((ra == SP_REG) ? sp_m1 : a_r) + ri;
          end
          OP_POP, OP_RET: begin
            mem_raddr = sp_r[MEM_AW-1:0];
            state_nxt = S_MEMW;
          end
          OP_LOAD: begin
            mem_raddr = b_rr[MEM_AW-1:0];
            state_nxt = S_MEMW;
          end
          OP_CALLR, OP_CALL: begin
            rf_we     = 1'b1;
            rf_waddr  = SP_REG;
            rf_wdata  = sp_m1;
            mem_we    = 1'b1;
            mem_waddr = sp_m1[MEM_AW-1:0];
            mem_wdata = {16'd0, pc_r};
            if (op == OP_CALLR) begin
              pc_nxt       = b_rr[15:0];
              wr2_addr_nxt = ra;
              wr2_data_nxt = {16'd0, pc_r} + 32'd1;
              state_nxt    = S_WR2;
            end else begin
              pc_nxt = ir_r[15:0];
            end
          end
          OP_CMP, OP_CMPI: begin
            shv = (op == OP_CMP) ? b_r : ri;
            if ($signed(a_r) > $signed(shv)) begin
              flag_nxt = FLAG_GT;
            end else if (a_r == shv) begin
              flag_nxt = FLAG_EQ;
            end else begin
              flag_nxt = FLAG_LT;
            end
          end
          OP_JMP: take = 1'b1;
          OP_JNE: take = (flag_r != FLAG_EQ);
          OP_JEQ: take = (flag_r == FLAG_EQ);
          OP_JLE: take = (flag_r != FLAG_GT);
          OP_JL:  take = (flag_r == FLAG_LT);
          OP_JGE: take = (flag_r != FLAG_LT);
          OP_JG:  take = (flag_r == FLAG_GT);
          default: st_nxt = ST_BADOP;
        endcase
        if (take) begin
          pc_nxt = ir_r[15:0];
        end
      end
      S_MEMW: begin
        state_nxt = S_OUT;
        case (op)
          OP_POP: begin
            // a pop into the stack pointer clears at the new top
            mem_we       = 1'b1;
            mem_waddr    = ((ra == SP_REG) ? popv[MEM_AW-1:0] : sp_r[MEM_AW-1:0]);
            mem_wdata    = 32'd0;
            rf_we        = 1'b1;
            rf_waddr     = ra;
            rf_wdata     = popv;
            wr2_addr_nxt = SP_REG;
            wr2_data_nxt = ((ra == SP_REG) ? popv : sp_r) + 32'd1;
            state_nxt    = S_WR2;
          end
          OP_RET: begin
            pc_nxt   = md[15:0];
            rf_we    = 1'b1;
            rf_waddr = SP_REG;
            rf_wdata = sp_r + rm32 + 32'd1;
          end
          default: begin
            rf_we    = 1'b1;
            rf_waddr = ra;
            rf_wdata = md;
          end
        endcase
      end
      S_MUL: begin
        rf_we        = 1'b1;
        rf_waddr     = ra;
        rf_wdata     = prod_r[31:0];
        wr2_addr_nxt = ra + REG_AW'(1);
        wr2_data_nxt = prod_r[63:32] - (mneg_r ? a_r : 32'd0);
        state_nxt    = S_WR2;
      end
      S_DIV: begin
        if (!ddif[32]) begin
          rem_nxt = ddif[31:0];
          quo_nxt = {quo_r[30:0], 1'b1};
        end else begin
          rem_nxt = dsh[31:0];
          quo_nxt = {quo_r[30:0], 1'b0};
        end
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          state_nxt = S_DIVW;
        end
      end
      S_DIVW: begin
        prod_nxt     = dneg_r ? (64'd0 - q64) : q64;
        rf_we        = 1'b1;
        rf_waddr     = ra;
        rf_wdata     = prod_nxt[31:0];
        wr2_addr_nxt = ra + REG_AW'(1);
        wr2_data_nxt = prod_nxt[63:32];
        state_nxt    = S_WR2;
      end
      S_WR2: begin
        rf_we     = 1'b1;
        rf_waddr  = wr2_addr_r;
        rf_wdata  = wr2_data_r;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_nxt.status     = st_r;
          out_nxt.next_pc    = pc_r;
          out_nxt.call_code  = code_r;
          out_nxt.call_reg   = creg_r;
          out_nxt.call_value = cval_r;
          out_valid_nxt      = 1'b1;
          state_nxt          = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (rf_we) begin
      rf_vld_nxt[rf_waddr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pc_r        <= 16'd0;
      flag_r      <= FLAG_EQ;
      exit_r      <= 20'd0;
      rf_vld_r    <= '0;
      rvld_r      <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= 5'd0;
    end else begin
      state_r     <= state_nxt;
      pc_r        <= pc_nxt;
      flag_r      <= flag_nxt;
      rf_vld_r    <= rf_vld_nxt;
      rvld_r      <= rvld_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      if (cfg_we) begin
        exit_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_r      <= out_nxt;
    ir_r       <= ir_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    sp_r       <= sp_nxt;
    st_r       <= st_nxt;
    code_r     <= code_nxt;
    creg_r     <= creg_nxt;
    cval_r     <= cval_nxt;
    prod_r     <= prod_nxt;
    mneg_r     <= mneg_nxt;
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    dvs_r      <= dvs_nxt;
    dneg_r     <= dneg_nxt;
    wr2_addr_r <= wr2_addr_nxt;
    wr2_data_r <= wr2_data_nxt;
  end

  a_load_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_data.func == FN_LOAD) |=> state_r == S_OUT)
    else $error("load request did not go to result");

  a_start_sp: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_data.func == FN_START) |=> rf_vld_r[SP_REG])
    else $error("start did not set stack pointer");

  a_step_pc: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_data.func == FN_STEP) |=> pc_r == $past(pc_r) + 16'd1)
    else $error("step did not advance pc");

  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_OUT)
    else $error("result raised outside result state");

endmodule
`default_nettype wire
